// ===== rtl/mfsc_pkg.sv =====
package mfsc_pkg;

  localparam int COORD_BITS = 13;
  localparam int CNT_BITS   = 3;
  localparam int THR_BITS   = 12;
  localparam int DIR_BITS   = 4;
  localparam int CFG_BITS   = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int CMP_BITS   = ((DELTA_BITS > THR_BITS + 1) ? DELTA_BITS : THR_BITS + 1) + 1;

  typedef enum logic [0:0] {
    REG_MOVE_THRESHOLD = 1'b0,
    REG_MIN_FINGERS    = 1'b1
  } cfg_reg_t;

  localparam logic [THR_BITS-1:0] THRESHOLD_RESET   = THR_BITS'(256);
  localparam logic [CNT_BITS-1:0] MIN_FINGERS_RESET = CNT_BITS'(3);

  typedef logic signed [1:0] axis_t;

  function automatic axis_t axis_sign(input logic [COORD_BITS-1:0] from,
                                      input logic [COORD_BITS-1:0] to,
                                      input logic [THR_BITS-1:0] thr);
    logic signed [CMP_BITS-1:0] d;
    logic signed [CMP_BITS-1:0] t;
    axis_t result;
    d = signed'(CMP_BITS'(to)) - signed'(CMP_BITS'(from));
    t = signed'(CMP_BITS'(thr));
    if (d < -t) begin
      result = 2'sb11;
    end else if (d > t) begin
      result = 2'sb01;
    end else begin
      result = 2'sb00;
    end
    return result;
  endfunction

  function automatic logic signed [DIR_BITS-1:0] combine_dir(input axis_t v, input axis_t h);
    logic signed [DIR_BITS-1:0] vv;
    logic signed [DIR_BITS-1:0] hh;
    vv = DIR_BITS'(v);
    hh = DIR_BITS'(h);
    return (vv <<< 1) + vv + hh;
  endfunction

endpackage

// ===== rtl/multi_finger_swipe_classifier.sv =====
// Classifies multi-finger swipes from a stream of touchpad samples. One sample
// transaction is taken per clock cycle while the input is not stalled; the
// gesture state is updated in the same cycle, and a finished gesture appears
// in the output register in the cycle after the sample that ends it. The
// input stalls only if the output register is full and out_stall is high. A
// gesture starts when the finger count reaches min_fingers and rises above the
// tracked count, and ends with one result when the count drops; after that the
// block ignores samples until all fingers lift. The direction is 3*vertical +
// horizontal, where each axis counts only when its delta is strictly beyond
// move_threshold. Configuration writes take effect at the next clock edge.
module multi_finger_swipe_classifier
  import mfsc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [0:0]                 cfg_index,
  input  logic [CFG_BITS-1:0]        cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CNT_BITS-1:0]        finger_count,
  input  logic [COORD_BITS-1:0]      pos_x,
  input  logic [COORD_BITS-1:0]      pos_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [CNT_BITS-1:0]        gesture_fingers,
  output logic signed [DIR_BITS-1:0] direction
);

  logic [THR_BITS-1:0]   move_threshold;
  logic [CNT_BITS-1:0]   min_fingers;
  logic [CNT_BITS-1:0]   tracked_fingers;
  logic [CNT_BITS-1:0]   tracked_fingers_next;
  logic                  wait_for_lift;
  logic                  wait_for_lift_next;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] last_x;
  logic [COORD_BITS-1:0] last_y;
  logic                  in_accept;
  logic                  do_start;
  logic                  do_refresh;
  logic                  emit;
  logic signed [DIR_BITS-1:0] dir_calc;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign do_start   = !wait_for_lift && (finger_count >= min_fingers)
                      && (finger_count > tracked_fingers);
  assign do_refresh = !wait_for_lift && (finger_count >= min_fingers)
                      && (finger_count == tracked_fingers);
  assign emit       = !wait_for_lift && (finger_count < tracked_fingers);
  assign dir_calc   = combine_dir(axis_sign(start_y, last_y, move_threshold),
                                  axis_sign(start_x, last_x, move_threshold));

  always_comb begin
    tracked_fingers_next = tracked_fingers;
    wait_for_lift_next   = wait_for_lift;
    if (do_start) begin
      tracked_fingers_next = finger_count;
    end
    if (emit) begin
      tracked_fingers_next = '0;
      wait_for_lift_next   = 1'b1;
    end
    if (finger_count == '0) begin
      tracked_fingers_next = '0;
      wait_for_lift_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold <= THRESHOLD_RESET;
      min_fingers    <= MIN_FINGERS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MOVE_THRESHOLD: move_threshold <= cfg_data[THR_BITS-1:0];
        REG_MIN_FINGERS:    min_fingers    <= cfg_data[CNT_BITS-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_fingers <= '0;
      wait_for_lift   <= 1'b0;
    end else if (in_accept) begin
      tracked_fingers <= tracked_fingers_next;
      wait_for_lift   <= wait_for_lift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (do_start || do_refresh)) begin
      last_x <= pos_x;
      last_y <= pos_y;
    end
    if (in_accept && do_start) begin
      start_x <= pos_x;
      start_y <= pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      gesture_fingers <= tracked_fingers;
      direction       <= dir_calc;
    end
  end

  a_lock_clears_track: assert property (@(posedge clk) disable iff (rst)
    wait_for_lift |-> tracked_fingers == '0)
    else $error("Tracked count is nonzero while locked.");

  a_emit_sets_output: assert property (@(posedge clk) disable iff (rst)
    (in_accept && emit) |=> out_valid && (wait_for_lift == ($past(finger_count) != '0)))
    else $error("Finished gesture did not reach the output register.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("Input stalled with an empty output register.");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (in_accept && emit) |=> gesture_fingers != '0)
    else $error("Result carries a zero finger count.");

endmodule

// ===== verif/multi_finger_swipe_classifier_tb.sv =====
`timescale 1ns / 100ps

module multi_finger_swipe_classifier_tb;
  import mfsc_pkg::*;

  typedef struct {
    logic [CNT_BITS-1:0]        fingers;
    logic signed [DIR_BITS-1:0] dir;
  } swipe_t;

  class swipe_scoreboard;
    logic [THR_BITS-1:0]   threshold;
    logic [CNT_BITS-1:0]   min_count;
    logic [CNT_BITS-1:0]   tracked;
    bit                    locked;
    logic [COORD_BITS-1:0] sx, sy, lx, ly;
    swipe_t                pending_swipes[$];
    int                    errors;

    function new();
      threshold = THRESHOLD_RESET;
      min_count = MIN_FINGERS_RESET;
      tracked = '0;
      locked = 1'b0;
      sx = '0;
      sy = '0;
      lx = '0;
      ly = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] value);
      case (idx)
        REG_MOVE_THRESHOLD: threshold = value[THR_BITS-1:0];
        REG_MIN_FINGERS: min_count = value[CNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int axis_move(logic [COORD_BITS-1:0] from, logic [COORD_BITS-1:0] to);
      int d;
      int t;
      d = int'(to) - int'(from);
      t = int'(threshold);
      if (d < -t) return -1;
      if (d > t) return 1;
      return 0;
    endfunction

    function void track_sample(logic [CNT_BITS-1:0] cnt, logic [COORD_BITS-1:0] x,
                               logic [COORD_BITS-1:0] y);
      swipe_t s;
      int dir;
      if (!locked) begin
        if (cnt >= min_count) begin
          if (cnt > tracked) begin
            sx = x;
            sy = y;
            lx = x;
            ly = y;
            tracked = cnt;
          end else if (cnt == tracked) begin
            lx = x;
            ly = y;
          end
        end
        if (cnt < tracked) begin
          dir = 3 * axis_move(sy, ly) + axis_move(sx, lx);
          s.fingers = tracked;
          s.dir = DIR_BITS'(dir);
          pending_swipes.push_back(s);
          tracked = '0;
          locked = 1'b1;
        end
      end
      if (cnt == 0) begin
        locked = 1'b0;
        tracked = '0;
      end
    endfunction

    function void check_swipe(logic [CNT_BITS-1:0] fingers, logic signed [DIR_BITS-1:0] dir);
      swipe_t s;
      if (pending_swipes.size() == 0) begin
        $display("%0t: unexpected gesture, expected none, actual fingers %0d direction %0d",
                 $time, fingers, dir);
        errors++;
        return;
      end
      s = pending_swipes.pop_front();
      if (fingers !== s.fingers) begin
        $display("%0t: gesture_fingers expected %0d actual %0d", $time, s.fingers, fingers);
        errors++;
      end
      if (dir !== s.dir) begin
        $display("%0t: direction expected %0d actual %0d", $time, s.dir, dir);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [0:0]                 cfg_index = REG_MOVE_THRESHOLD;
  logic [CFG_BITS-1:0]        cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [CNT_BITS-1:0]        finger_count = '0;
  logic [COORD_BITS-1:0]      pos_x = '0;
  logic [COORD_BITS-1:0]      pos_y = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [CNT_BITS-1:0]        gesture_fingers;
  logic signed [DIR_BITS-1:0] direction;

  swipe_scoreboard sb = new();
  int items_sent = 0;
  int gap_max = 16;
  int stall_max = 16;
  int hold_cycles = 0;

  multi_finger_swipe_classifier uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .finger_count(finger_count),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .gesture_fingers(gesture_fingers),
    .direction(direction)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_sample(input int cnt, input int x, input int y);
    int gap;
    gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    finger_count <= CNT_BITS'(cnt);
    pos_x <= COORD_BITS'(x);
    pos_y <= COORD_BITS'(y);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.track_sample(finger_count, pos_x, pos_y);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_swipes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input int thr, input int minf);
    cfg_write <= 1'b1;
    cfg_index <= REG_MOVE_THRESHOLD;
    cfg_data <= CFG_BITS'(thr);
    @(posedge clk);
    sb.write_reg(REG_MOVE_THRESHOLD, CFG_BITS'(thr));
    cfg_index <= REG_MIN_FINGERS;
    cfg_data <= CFG_BITS'(minf);
    @(posedge clk);
    sb.write_reg(REG_MIN_FINGERS, CFG_BITS'(minf));
    cfg_write <= 1'b0;
  endtask

  function automatic int pick_delta();
    int thr;
    thr = int'(sb.threshold);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return thr;
      2: return thr + 1;
      3: return -thr;
      4: return -thr - 1;
      default: return int'($urandom_range(0, 16383)) - 8192;
    endcase
  endfunction

  // A well-formed swipe: [lift], [partial touch], start, moves, drop, [tail].
  task automatic random_swipe();
    int lo, n, sx, sy, moves, end_cnt;
    lo = (sb.min_count == 0) ? 1 : int'(sb.min_count);
    n = $urandom_range(lo, 7);
    if ($urandom_range(0, 3) != 0)
      send_sample(0, $urandom_range(0, 8191), $urandom_range(0, 8191));
    if ($urandom_range(0, 3) == 0)
      send_sample($urandom_range(0, n - 1), $urandom_range(0, 8191), $urandom_range(0, 8191));
    sx = $urandom_range(0, 8191);
    sy = $urandom_range(0, 8191);
    send_sample(n, sx, sy);
    moves = $urandom_range(0, 4);
    for (int k = 0; k < moves; k++) begin
      if ($urandom_range(0, 7) == 0 && n < 7) begin
        n++;
        sx = $urandom_range(0, 8191);
        sy = $urandom_range(0, 8191);
        send_sample(n, sx, sy);
      end else begin
        send_sample(n, sx + pick_delta(), sy + pick_delta());
      end
    end
    end_cnt = $urandom_range(0, n - 1);
    send_sample(end_cnt, $urandom_range(0, 8191), $urandom_range(0, 8191));
    if (end_cnt != 0 && $urandom_range(0, 1) == 0)
      send_sample($urandom_range(0, 7), $urandom_range(0, 8191), $urandom_range(0, 8191));
  endtask

  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, stall_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_swipe(gesture_fingers, direction);
    end
  end

  initial begin
    int phase, target, thr, minf;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(0, 0, 0);
    send_sample(3, 0, 0);
    send_sample(3, 8191, 8191);
    send_sample(2, 17, 17);
    send_sample(1, 5, 5);
    send_sample(0, 0, 0);
    send_sample(4, 4000, 4000);
    send_sample(5, 4100, 4100);
    send_sample(5, 4356, 3843);
    send_sample(2, 0, 0);
    send_sample(0, 0, 0);
    send_sample(2, 1234, 4321);
    send_sample(7, 8191, 0);
    send_sample(7, 0, 8191);
    send_sample(6, 0, 0);
    send_sample(0, 0, 0);

    wait_idle();
    write_config(0, 0);
    send_sample(0, 100, 100);
    send_sample(1, 100, 100);
    send_sample(1, 101, 99);
    send_sample(0, 0, 0);

    wait_idle();
    write_config(4095, 7);
    send_sample(7, 0, 0);
    send_sample(7, 4095, 4096);
    send_sample(3, 0, 0);
    send_sample(0, 0, 0);

    phase = 0;
    while (items_sent < 870) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0: thr = 0;
        1: thr = 4095;
        2: thr = $urandom_range(0, 4095);
        default: thr = $urandom_range(0, 600);
      endcase
      minf = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : $urandom_range(1, 4);
      write_config(thr, minf);
      gap_max = (phase % 3 == 0) ? 0 : 16;
      stall_max = (phase % 4 == 1) ? 0 : 16;
      if (phase == 3) hold_cycles = 120;
      target = items_sent + $urandom_range(30, 80);
      while (items_sent < target) begin
        if ($urandom_range(0, 5) == 0)
          send_sample($urandom_range(0, 7), $urandom_range(0, 8191), $urandom_range(0, 8191));
        else
          random_swipe();
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (sb.pending_swipes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("multi_finger_swipe_classifier regression: pass");
    end else begin
      $display("multi_finger_swipe_classifier regression: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("multi_finger_swipe_classifier regression: fail");
    $finish;
  end

endmodule

// ===== multi_finger_swipe_classifier.f =====
rtl/mfsc_pkg.sv
rtl/multi_finger_swipe_classifier.sv
verif/multi_finger_swipe_classifier_tb.sv
